// File: hdl/ratt_pkg.sv
// shared types and constants of the range address translation table
package ratt_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = 9;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] PROFILE_MASK = 64'h0000_0000_0000_00F0;
   localparam logic [63:0] PROFILE_DUP  = 64'h0000_0000_0000_0020;
   localparam logic [63:0] USABLE_DEV   = 64'd1;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_ADD,
      OP_LOOKUP,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] logical_addr;
      logic [63:0] span_bytes;
      logic [63:0] physical_base;
      logic [63:0] group_type;
      logic [63:0] device_id;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [63:0]      mapped_addr;
      logic [CNT_W-1:0] entries_used;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type      op;
      logic [63:0] logical_addr;
      logic [63:0] span_bytes;
      logic [63:0] physical_base;
      logic        usable;
      logic        span_zero;
   } cmd_type;

   typedef struct packed {
      logic [63:0] logical;
      logic [63:0] length;
      logic [63:0] physical;
      logic        usable;
   } entry_type;

endpackage

// File: hdl/ratt_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module ratt_front import ratt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_pop,
   output cmd_type q_cmd
);

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   cmd_type            cls_cmd;
   logic [63:0]        profile;
   logic               push;
   logic               pop;

   always_comb begin
      profile               = req_data.group_type & PROFILE_MASK;
      cls_cmd.logical_addr  = req_data.logical_addr;
      cls_cmd.span_bytes    = req_data.span_bytes;
      cls_cmd.physical_base = req_data.physical_base;
      cls_cmd.span_zero     = (req_data.span_bytes == 64'd0);
      cls_cmd.usable        = ((profile == 64'd0) || (profile == PROFILE_DUP)) &&
                              (req_data.device_id == USABLE_DEV);
      case (func_type'(req_data.func))
         FUNC_CLEAR:  cls_cmd.op = OP_CLEAR;
         FUNC_ADD:    cls_cmd.op = OP_ADD;
         FUNC_LOOKUP: cls_cmd.op = OP_LOOKUP;
         default:     cls_cmd.op = OP_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls_cmd;
      end
   end

endmodule

// File: hdl/ratt_back.sv
// back end: range table storage, add/clear execution and pipelined lookup scan
module ratt_back import ratt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_pop,
   input  cmd_type q_cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   entry_type         table_mem [TABLE_ENTRIES];
   entry_type         rd_ff;
   entry_type         wr_entry;
   logic              mem_we;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   cmd_type           cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // scan pipeline: read data, offset stage, range stage
   logic              s1_vld_ff, s1_vld_in;
   logic              s2_vld_ff, s2_vld_in;
   logic              s3_vld_ff, s3_vld_in;
   logic              s2_ge_ff, s2_ge_in;
   logic [63:0]       s2_off_ff, s2_off_in;
   logic [63:0]       s2_len_ff;
   logic [63:0]       s2_phys_ff;
   logic              s2_usable_ff;
   logic              s3_ge_ff;
   logic              s3_inr_ff, s3_inr_in;
   logic [63:0]       s3_rem_ff, s3_rem_in;
   logic [63:0]       s3_map_ff, s3_map_in;
   logic              s3_usable_ff;

   logic [64:0]       off_diff;
   logic [64:0]       rem_diff;
   logic              out_free;
   logic              issue;
   logic              hit;
   logic              drained;
   logic              finish;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign issue = (state_ff == ST_SCAN) && (scan_idx_ff != count_ff) && !finish;

   // offset of the lookup address into the entry; borrow means below base
   assign off_diff  = {1'b0, cur_ff.logical_addr} - {1'b0, rd_ff.logical};
   assign s2_ge_in  = !off_diff[64];
   assign s2_off_in = off_diff[63:0];

   // room left in the entry after the offset; must be nonzero
   assign rem_diff  = {1'b0, s2_len_ff} - {1'b0, s2_off_ff};
   assign s3_inr_in = !rem_diff[64] && (rem_diff[63:0] != 64'd0);
   assign s3_rem_in = rem_diff[63:0];
   assign s3_map_in = s2_phys_ff + s2_off_ff;

   assign hit     = s3_vld_ff && s3_ge_ff && s3_inr_ff && (cur_ff.span_bytes <= s3_rem_ff);
   assign drained = (scan_idx_ff == count_ff) && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;
   assign finish  = (state_ff == ST_SCAN) && (hit || drained);

   assign s1_vld_in = issue;
   assign s2_vld_in = s1_vld_ff && !finish;
   assign s3_vld_in = s2_vld_ff && !finish;

   always_comb begin
      wr_entry.logical  = q_cmd.logical_addr;
      wr_entry.length   = q_cmd.span_bytes;
      wr_entry.physical = q_cmd.physical_base;
      wr_entry.usable   = q_cmd.usable;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop                    = 1'b1;
               rsp_data_in.ok           = 1'b0;
               rsp_data_in.mapped_addr  = 64'd0;
               rsp_data_in.entries_used = count_ff;
               case (q_cmd.op)
                  OP_CLEAR: begin
                     count_in                 = '0;
                     rsp_data_in.entries_used = '0;
                     rsp_valid_in             = 1'b1;
                  end
                  OP_ADD: begin
                     if (!q_cmd.span_zero && (count_ff < CNT_W'(TABLE_ENTRIES))) begin
                        mem_we                   = 1'b1;
                        count_in                 = count_ff + 1'b1;
                        rsp_data_in.ok           = 1'b1;
                        rsp_data_in.entries_used = count_ff + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_LOOKUP: begin
                     if (q_cmd.span_zero || (count_ff == '0)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        cur_in      = q_cmd;
                        scan_idx_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (finish) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.ok           = hit && s3_usable_ff;
               rsp_data_in.mapped_addr  = (hit && s3_usable_ff) ? s3_map_ff : 64'd0;
               rsp_data_in.entries_used = count_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
      end
      cur_ff       <= cur_in;
      rsp_data_ff  <= rsp_data_in;
      s2_ge_ff     <= s2_ge_in;
      s2_off_ff    <= s2_off_in;
      s2_len_ff    <= rd_ff.length;
      s2_phys_ff   <= rd_ff.physical;
      s2_usable_ff <= rd_ff.usable;
      s3_ge_ff     <= s2_ge_ff;
      s3_inr_ff    <= s3_inr_in;
      s3_rem_ff    <= s3_rem_in;
      s3_map_ff    <= s3_map_in;
      s3_usable_ff <= s2_usable_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_ff <= table_mem[scan_idx_ff[IDX_W-1:0]];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_idx_ff <= count_ff)
      else $error("scan index ran past entry count");

   a_scan_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !rsp_valid_ff)
      else $error("result pending while a lookup scan runs");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd.op == OP_CLEAR) |=> (count_ff == '0 && rsp_valid_ff))
      else $error("clear did not empty the table");

endmodule

// File: hdl/range_address_translation_table_core.sv
// Range address translation table: up to 256 logical-to-physical ranges.
// Requests pass through a two-deep queue from the front end to the back end.
// Clear, add and unused codes complete without a scan. A lookup scans
// the stored ranges in insertion order through a pipeline of read, offset
// and range stages on the single read port of the range memory, one entry
// per cycle, and stops at the first range that holds the whole span. One
// request is executed at a time.
module range_address_translation_table_core import ratt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   ratt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd)
   );

   ratt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/range_address_translation_table_core_test.sv
// self-checking testbench for the range address translation table core
module range_address_translation_table_core_test;
   import ratt_pkg::*;

   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_BASE  = 64'hFFFF_FFFF_FFFF_FF00;
   localparam logic [63:0] TOP_PHYS  = 64'hFFFF_FFFF_FFFF_FFF0;
   localparam int RANDOM_ITEMS = 1525;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 700;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef struct packed {
      func_type         func;
      logic [63:0]      addr;
      logic [63:0]      span;
      logic [63:0]      phys;
      logic [63:0]      gtype;
      logic [63:0]      dev;
      bit               fixed;
      bit               want_ok;
      logic [CNT_W-1:0] want_used;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow of the range table
   logic [63:0] tbl_logical [TABLE_ENTRIES];
   logic [63:0] tbl_length [TABLE_ENTRIES];
   logic [63:0] tbl_physical [TABLE_ENTRIES];
   logic        tbl_usable [TABLE_ENTRIES];
   int          tbl_count = 0;

   rsp_type awaited_rsps [$];
   int      mismatch_count = 0;
   int      result_count = 0;
   int      cycle_count = 0;
   int      accepted_items = 0;
   bit      sender_calm = 1'b0;
   bit      receiver_calm = 1'b0;

   // fixed rows carry the result that can be read off directly (mapped address is then 0)
   directed_row_type directed_rows [25] = '{
      '{FUNC_LOOKUP, 64'h10,   64'h10,   64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd0},
      '{FUNC_CLEAR,  64'h0,    64'h0,    64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd0},
      '{FUNC_ADD,    64'h40,   64'h0,    64'h9000, 64'h0,    64'h1,    1'b1, 1'b0, 9'd0},
      '{FUNC_ADD,    64'h0,    64'h100,  64'h1000, 64'h0,    64'h1,    1'b1, 1'b1, 9'd1},
      '{FUNC_LOOKUP, 64'h10,   64'h10,   64'h0,    64'h0,    64'h0,    1'b0, 1'b0, 9'd0},
      '{FUNC_LOOKUP, 64'h10,   64'h0,    64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd1},
      '{FUNC_LOOKUP, 64'h30,   64'h100,  64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd1},
      '{FUNC_ADD,    TOP_BASE, 64'h100,  TOP_PHYS, 64'h20,   64'h1,    1'b1, 1'b1, 9'd2},
      '{FUNC_LOOKUP, ALL_ONES, 64'h1,    64'h0,    64'h0,    64'h0,    1'b0, 1'b0, 9'd0},
      '{FUNC_ADD,    64'h2000, 64'h100,  64'h5000, 64'h30,   64'h1,    1'b1, 1'b1, 9'd3},
      '{FUNC_ADD,    64'h2000, 64'h200,  64'h6000, 64'h20F,  64'h1,    1'b1, 1'b1, 9'd4},
      '{FUNC_LOOKUP, 64'h2010, 64'h10,   64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd4},
      '{FUNC_LOOKUP, 64'h2100, 64'h100,  64'h0,    64'h0,    64'h0,    1'b0, 1'b0, 9'd0},
      '{FUNC_ADD,    64'h3000, 64'h10,   64'h0,    64'h0,    64'h0,    1'b1, 1'b1, 9'd5},
      '{FUNC_ADD,    64'h3000, 64'h10,   64'h0,    64'h0,    ALL_ONES, 1'b1, 1'b1, 9'd6},
      '{FUNC_LOOKUP, 64'h3000, 64'h10,   64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd6},
      '{FUNC_ADD,    64'h0,    ALL_ONES, ALL_ONES, ALL_ONES, 64'h1,    1'b1, 1'b1, 9'd7},
      '{FUNC_ADD,    64'h8000, 64'h4000, 64'h0,    64'h0,    64'h1,    1'b1, 1'b1, 9'd8},
      '{FUNC_LOOKUP, 64'h9000, 64'h1000, 64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd8},
      '{FUNC_LOOKUP, ALL_ONES, ALL_ONES, 64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd8},
      '{FUNC_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b0, 9'd8},
      '{FUNC_CLEAR,  64'h0,    64'h0,    64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd0},
      '{FUNC_LOOKUP, 64'h10,   64'h1,    64'h0,    64'h0,    64'h0,    1'b1, 1'b0, 9'd0},
      '{FUNC_ADD,    64'h0,    64'h1,    64'h0,    64'h0,    64'h1,    1'b1, 1'b1, 9'd1},
      '{FUNC_LOOKUP, 64'h0,    64'h1,    64'h0,    64'h0,    64'h0,    1'b0, 1'b0, 9'd0}
   };

   range_address_translation_table_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // applies one request to the shadow table and returns the result it should give
   function automatic rsp_type predict_translation(input req_type r);
      rsp_type     res;
      logic [63:0] off;
      logic [63:0] prof;
      bit          decided;
      int          k;
      res = '0;
      decided = 1'b0;
      case (func_type'(r.func))
         FUNC_CLEAR: begin
            tbl_count = 0;
         end
         FUNC_ADD: begin
            if (r.span_bytes != 0 && tbl_count < TABLE_ENTRIES) begin
               prof = r.group_type & PROFILE_MASK;
               tbl_logical[tbl_count] = r.logical_addr;
               tbl_length[tbl_count] = r.span_bytes;
               tbl_physical[tbl_count] = r.physical_base;
               tbl_usable[tbl_count] = (prof == 0 || prof == PROFILE_DUP)
                                       && r.device_id == USABLE_DEV;
               tbl_count++;
               res.ok = 1'b1;
            end
         end
         FUNC_LOOKUP: begin
            if (r.span_bytes != 0) begin
               for (k = 0; k < tbl_count && !decided; k++) begin
                  if (r.logical_addr >= tbl_logical[k]) begin
                     off = r.logical_addr - tbl_logical[k];
                     if (off < tbl_length[k] && r.span_bytes <= tbl_length[k] - off) begin
                        // first containing range decides, usable or not
                        decided = 1'b1;
                        if (tbl_usable[k]) begin
                           res.ok = 1'b1;
                           res.mapped_addr = tbl_physical[k] + off;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      res.entries_used = CNT_W'(tbl_count);
      return res;
   endfunction

   function automatic req_type make_add();
      req_type r;
      int      pick;
      r = '0;
      r.func = FUNC_ADD;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         r.logical_addr = 64'($urandom_range(0, 63)) << 8;
      else if (pick < 8)
         r.logical_addr = rand64();
      else
         r.logical_addr = ALL_ONES - 64'($urandom_range(0, 4095));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.span_bytes = 64'h0;
      else if (pick == 1)
         r.span_bytes = rand64();
      else if (pick == 2)
         r.span_bytes = ALL_ONES - 64'($urandom_range(0, 255));
      else
         r.span_bytes = 64'($urandom_range(1, 1024));
      r.physical_base = rand64();
      r.group_type = rand64();
      if ($urandom_range(0, 3) != 0)
         r.group_type[7:4] = $urandom_range(0, 1) ? 4'h2 : 4'h0;
      pick = $urandom_range(0, 7);
      r.device_id = (pick < 6) ? USABLE_DEV : (pick == 6 ? 64'h0 : rand64());
      return r;
   endfunction

   function automatic req_type make_lookup();
      req_type     r;
      logic [63:0] room;
      logic [63:0] off;
      int          k;
      int          pick;
      r = '0;
      r.func = FUNC_LOOKUP;
      if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
         // aim inside a stored range
         k = $urandom_range(0, tbl_count - 1);
         off = ($urandom_range(0, 1) && tbl_length[k] > 64'h40) ?
               64'($urandom_range(0, 63)) : rand64() % tbl_length[k];
         r.logical_addr = tbl_logical[k] + off;
         room = tbl_length[k] - off;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            r.span_bytes = room;
         else if (pick == 1)
            r.span_bytes = room + 1;
         else if (pick == 2)
            r.span_bytes = 64'h0;
         else if (pick == 3)
            r.span_bytes = 64'h1 + rand64() % room;
         else
            r.span_bytes = (room < 32) ? room : 64'($urandom_range(1, 32));
      end else begin
         r.logical_addr = $urandom_range(0, 1) ? 64'($urandom_range(0, 20'hFFFFF)) : rand64();
         r.span_bytes = $urandom_range(0, 2) ? 64'($urandom_range(0, 512)) : rand64();
      end
      r.physical_base = rand64();
      r.group_type = rand64();
      r.device_id = rand64();
      return r;
   endfunction

   function automatic req_type make_noise(input func_type f);
      req_type r;
      r.func = f;
      r.logical_addr = rand64();
      r.span_bytes = rand64();
      r.physical_base = rand64();
      r.group_type = rand64();
      r.device_id = rand64();
      return r;
   endfunction

   // offers one request and returns at the edge where it is taken
   task automatic send_request(input req_type r, input bit fixed, input rsp_type fixed_rsp);
      int      gap;
      rsp_type predicted;
      gap = sender_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      predicted = predict_translation(r);
      awaited_rsps.push_back(fixed ? fixed_rsp : predicted);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_items++;
   endtask

   task automatic send_checked(input req_type r);
      send_request(r, 1'b0, '0);
   endtask

   task automatic run_small_episode();
      int n;
      int pick;
      if ($urandom_range(0, 3) != 0)
         send_checked(make_noise(FUNC_CLEAR));
      n = $urandom_range(1, 16);
      repeat (n) send_checked(make_add());
      n = $urandom_range(8, 40);
      repeat (n) begin
         pick = $urandom_range(0, 19);
         if (pick < 12)
            send_checked(make_lookup());
         else if (pick < 15)
            send_checked(make_add());
         else if (pick < 17)
            send_checked(make_noise(FUNC_UNUSED));
         else if (pick < 18)
            send_checked(make_noise(FUNC_CLEAR));
         else
            send_checked(make_noise(func_type'($urandom_range(0, 3))));
      end
   endtask

   // fills the table, pushes adds against the full table, then scans it
   task automatic run_fill_episode();
      req_type r;
      send_checked(make_noise(FUNC_CLEAR));
      while (tbl_count < TABLE_ENTRIES) begin
         r = make_add();
         if ($urandom_range(0, 3) != 0)
            r.span_bytes = 64'($urandom_range(1, 64));
         send_checked(r);
      end
      repeat (3) send_checked(make_add());
      repeat (12) send_checked(make_lookup());
   endtask

   initial begin : request_side
      req_type r;
      rsp_type want;
      int      episode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r.func = directed_rows[i].func;
         r.logical_addr = directed_rows[i].addr;
         r.span_bytes = directed_rows[i].span;
         r.physical_base = directed_rows[i].phys;
         r.group_type = directed_rows[i].gtype;
         r.device_id = directed_rows[i].dev;
         want.ok = directed_rows[i].want_ok;
         want.mapped_addr = 64'h0;
         want.entries_used = directed_rows[i].want_used;
         send_request(r, directed_rows[i].fixed, want);
      end

      accepted_items = 0;
      episode = 0;
      while (accepted_items < RANDOM_ITEMS) begin
         sender_calm = ($urandom_range(0, 4) == 0);
         receiver_calm = ($urandom_range(0, 4) == 0);
         if (episode == 2 || episode == 7)
            run_fill_episode();
         else
            run_small_episode();
         episode++;
      end
      req_valid <= 1'b0;

      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : result_side
      int      stall;
      bit      hold_done;
      rsp_type want;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, 9);
         // one long hold-off so the request queue backs up
         if (result_count == HOLD_AFTER && !hold_done) begin
            stall = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (awaited_rsps.size() == 0) begin
            $error("result transfer with no prediction waiting");
            mismatch_count++;
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_data.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
               mismatch_count++;
            end
            if (rsp_data.mapped_addr !== want.mapped_addr) begin
               $error("mapped_addr: expected %h, got %h", want.mapped_addr,
                      rsp_data.mapped_addr);
               mismatch_count++;
            end
            if (rsp_data.entries_used !== want.entries_used) begin
               $error("entries_used: expected %0d, got %0d", want.entries_used,
                      rsp_data.entries_used);
               mismatch_count++;
            end
         end
         result_count++;
      end
   end

endmodule
